/* hdl/indexed_min_heap_queue_macros.svh */
// assertion macros used by the heap queue datapath
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IMHQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`define IMHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IMHQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define IMHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* hdl/imhq_pkg.sv */
// types and constants of the indexed min-heap queue
package imhq_pkg;
  localparam int unsigned CAPACITY_DEF = 128;
  localparam int unsigned ITEMS        = 128;
  localparam int unsigned ID_W         = 7;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned COUNT_W      = 8;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_EXTRACT  = 2'd1,
    CMD_DECREASE = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUP       = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_NOT_LOWER = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_EX_RD0, S_EX_RDL, S_DN_RDL, S_DN_RDR, S_DN_CMPR, S_DN_CMP,
    S_UP_CHK, S_UP_CMP, S_DK_SLOT, S_DK_KEY, S_FIN, S_ROOT
  } state_e;

  typedef enum logic [2:0] {
    RD_ROOT, RD_LAST, RD_LEFT, RD_RIGHT, RD_PARENT, RD_SLOT
  } rd_sel_e;

  typedef struct packed {
    logic [ID_W-1:0]         item;
    logic signed [KEY_W-1:0] key;
  } heap_ent_t;

  typedef struct packed {
    logic    load_in;
    logic    set_status;
    status_e status;
    logic    ins_start;
    logic    ex_take_root;
    logic    ex_load_last;
    logic    cand_left;
    logic    cand_right;
    logic    descend;
    logic    ascend;
    logic    wr_moving;
    logic    dk_hole;
    logic    dk_moving;
    logic    heap_re;
    rd_sel_e heap_sel;
    logic    slot_re;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic present;
    logic full;
    logic empty;
    logic one_left;
    logic left_ok;
    logic right_ok;
    logic at_root;
    logic right_wins;
    logic sink_more;
    logic rise_more;
    logic slot_bad;
    logic not_lower;
    logic out_busy;
  } dp_stat_t;
endpackage

/* hdl/imhq_ram.sv */
// generic single-write, single-read memory with registered read
module imhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* hdl/imhq_datapath.sv */
// heap memories, moving-entry registers, compares and result register
`include "indexed_min_heap_queue_macros.svh"
module imhq_datapath import imhq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic [1:0]               cmd_in_i,
  input  logic [ID_W-1:0]          item_id_i,
  input  logic signed [KEY_W-1:0]  new_key_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [ID_W-1:0]          out_id_o,
  output logic signed [KEY_W-1:0]  out_key_o,
  output logic [COUNT_W-1:0]       entry_count_o
);
  localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = SW + 2;
  localparam int unsigned HW = $bits(heap_ent_t);
  localparam int unsigned IW = $clog2(ITEMS);

  cmd_e                    cmd_q;
  logic [ID_W-1:0]         id_q;
  logic signed [KEY_W-1:0] key_q;
  heap_ent_t               mov_q, cand_q, res_q;
  logic [LW-1:0]           cand_addr_q;
  logic [SW-1:0]           hole_q;
  logic                    extracted_q;
  status_e                 status_q;
  logic [CW-1:0]           fill_q, fill_d;
  logic [ITEMS-1:0]        present_q, present_d;
  logic                    out_valid_q;
  logic [2:0]              out_status_q;
  heap_ent_t               out_ent_q;
  logic [COUNT_W-1:0]      out_count_q;

  logic                    heap_we;
  heap_ent_t               heap_wdata, heap_rdata;
  logic [HW-1:0]           heap_rraw;
  logic [SW-1:0]           heap_raddr;
  logic [SW-1:0]           slot_rdata;
  logic [LW-1:0]           left_addr, right_addr;
  logic [SW-1:0]           parent_addr;
  logic                    use_root;
  logic [31:0]             fill_wide;

  assign left_addr   = {1'b0, hole_q, 1'b1};
  assign right_addr  = left_addr + LW'(1);
  assign parent_addr = SW'((hole_q - SW'(1)) >> 1);
  assign heap_rdata  = heap_ent_t'(heap_rraw);

  always_comb begin
    case (cmd_i.heap_sel)
      RD_ROOT:   heap_raddr = '0;
      RD_LAST:   heap_raddr = SW'(fill_q - CW'(1));
      RD_LEFT:   heap_raddr = left_addr[SW-1:0];
      RD_RIGHT:  heap_raddr = right_addr[SW-1:0];
      RD_PARENT: heap_raddr = parent_addr;
      RD_SLOT:   heap_raddr = slot_rdata;
      default:   heap_raddr = '0;
    endcase
  end

  // entry written into the hole, and its position map update
  always_comb begin
    heap_we    = cmd_i.ascend | cmd_i.descend | cmd_i.wr_moving;
    heap_wdata = mov_q;
    if (cmd_i.ascend) begin
      heap_wdata = heap_rdata;
    end else if (cmd_i.descend) begin
      heap_wdata = cand_q;
    end
  end

  imhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (hole_q),
    .wdata_i (heap_wdata),
    .re_i    (cmd_i.heap_re),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rraw)
  );

  imhq_ram #(.WIDTH(SW), .DEPTH(ITEMS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (IW'(heap_wdata.item)),
    .wdata_i (hole_q),
    .re_i    (cmd_i.slot_re),
    .raddr_i (IW'(id_q)),
    .rdata_o (slot_rdata)
  );

  always_comb begin
    fill_d    = fill_q;
    present_d = present_q;
    if (cmd_i.ins_start) begin
      fill_d        = fill_q + CW'(1);
      present_d[id_q] = 1'b1;
    end
    if (cmd_i.ex_take_root) begin
      fill_d                    = fill_q - CW'(1);
      present_d[heap_rdata.item] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      present_q   <= present_d;
      out_valid_q <= cmd_i.out_load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q       <= cmd_e'(cmd_in_i);
      id_q        <= item_id_i;
      key_q       <= new_key_i;
      res_q       <= '0;
      extracted_q <= 1'b0;
      status_q    <= ST_OK;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.ins_start) begin
      mov_q  <= '{item: id_q, key: key_q};
      hole_q <= fill_q[SW-1:0];
    end
    if (cmd_i.ex_take_root) begin
      res_q       <= heap_rdata;
      extracted_q <= 1'b1;
    end
    if (cmd_i.ex_load_last) begin
      mov_q  <= heap_rdata;
      hole_q <= '0;
    end
    if (cmd_i.cand_left) begin
      cand_q      <= heap_rdata;
      cand_addr_q <= left_addr;
    end
    if (cmd_i.cand_right) begin
      cand_q      <= heap_rdata;
      cand_addr_q <= right_addr;
    end
    if (cmd_i.descend) begin
      hole_q <= cand_addr_q[SW-1:0];
    end
    if (cmd_i.ascend) begin
      hole_q <= parent_addr;
    end
    if (cmd_i.dk_hole) begin
      hole_q <= slot_rdata;
    end
    if (cmd_i.dk_moving) begin
      mov_q <= '{item: id_q, key: key_q};
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_ent_q    <= use_root ? heap_rdata : res_q;
      out_count_q  <= fill_wide[COUNT_W-1:0];
    end
  end

  assign use_root  = !extracted_q && (fill_q != '0);
  assign fill_wide = 32'(fill_q);

  assign stat_o.cmd        = cmd_q;
  assign stat_o.present    = present_q[id_q];
  assign stat_o.full       = (fill_q == CW'(CAPACITY));
  assign stat_o.empty      = (fill_q == '0);
  assign stat_o.one_left   = (fill_q == CW'(1));
  assign stat_o.left_ok    = (left_addr < LW'(fill_q));
  assign stat_o.right_ok   = (right_addr < LW'(fill_q));
  assign stat_o.at_root    = (hole_q == '0);
  assign stat_o.right_wins = !(cand_q.key < heap_rdata.key);
  assign stat_o.sink_more  = (mov_q.key > cand_q.key);
  assign stat_o.rise_more  = (heap_rdata.key > mov_q.key);
  assign stat_o.slot_bad   = (CW'(slot_rdata) >= fill_q);
  assign stat_o.not_lower  = (key_q >= heap_rdata.key);
  assign stat_o.out_busy   = out_valid_q & out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_id_o      = out_ent_q.item;
  assign out_key_o     = out_ent_q.key;
  assign entry_count_o = out_count_q;

  `IMHQ_ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= CW'(CAPACITY),
    "entry count above capacity")
  `IMHQ_ASSERT_IMPL(a_hole_live, clk_i, rst_ni, cmd_i.wr_moving, CW'(hole_q) < fill_q,
    "moving entry written outside the live heap")
  `IMHQ_ASSERT_IMPL(a_child_live, clk_i, rst_ni, cmd_i.descend, cand_addr_q < LW'(fill_q),
    "descent into a slot beyond the last entry")
endmodule

/* hdl/imhq_ctrl.sv */
// sequencer for insert, extract-min and decrease-key
module imhq_ctrl import imhq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);
  state_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:   if (in_valid_i) st_d = S_DECODE;
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_INSERT:   st_d = (stat_i.present || stat_i.full) ? S_FIN : S_UP_CHK;
          CMD_EXTRACT:  st_d = stat_i.empty ? S_FIN : S_EX_RD0;
          CMD_DECREASE: st_d = stat_i.present ? S_DK_SLOT : S_FIN;
          default:      st_d = S_FIN;
        endcase
      end
      S_EX_RD0:  st_d = stat_i.one_left ? S_FIN : S_EX_RDL;
      S_EX_RDL:  st_d = S_DN_RDL;
      S_DN_RDL:  st_d = stat_i.left_ok ? S_DN_RDR : S_FIN;
      S_DN_RDR:  st_d = stat_i.right_ok ? S_DN_CMPR : S_DN_CMP;
      S_DN_CMPR: st_d = S_DN_CMP;
      S_DN_CMP:  st_d = stat_i.sink_more ? S_DN_RDL : S_FIN;
      S_UP_CHK:  st_d = stat_i.at_root ? S_FIN : S_UP_CMP;
      S_UP_CMP:  st_d = stat_i.rise_more ? S_UP_CHK : S_FIN;
      S_DK_SLOT: st_d = stat_i.slot_bad ? S_FIN : S_DK_KEY;
      S_DK_KEY:  st_d = stat_i.not_lower ? S_FIN : S_UP_CHK;
      S_FIN:     st_d = S_ROOT;
      S_ROOT:    if (!stat_i.out_busy) st_d = S_IDLE;
      default:   st_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.status   = ST_OK;
    cmd_o.heap_sel = RD_ROOT;
    in_stall_o     = (st_q != S_IDLE);
    case (st_q)
      S_IDLE: cmd_o.load_in = in_valid_i;
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_INSERT: begin
            if (stat_i.present) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_DUP;
            end else if (stat_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.ins_start = 1'b1;
            end
          end
          CMD_EXTRACT: begin
            if (stat_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EMPTY;
            end else begin
              cmd_o.heap_re  = 1'b1;
              cmd_o.heap_sel = RD_ROOT;
            end
          end
          CMD_DECREASE: begin
            if (stat_i.present) begin
              cmd_o.slot_re = 1'b1;
            end else begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_ABSENT;
            end
          end
          default: ;
        endcase
      end
      S_EX_RD0: begin
        cmd_o.ex_take_root = 1'b1;
        cmd_o.heap_re      = !stat_i.one_left;
        cmd_o.heap_sel     = RD_LAST;
      end
      S_EX_RDL: cmd_o.ex_load_last = 1'b1;
      S_DN_RDL: begin
        cmd_o.heap_re   = stat_i.left_ok;
        cmd_o.heap_sel  = RD_LEFT;
        cmd_o.wr_moving = !stat_i.left_ok;
      end
      S_DN_RDR: begin
        cmd_o.cand_left = 1'b1;
        cmd_o.heap_re   = stat_i.right_ok;
        cmd_o.heap_sel  = RD_RIGHT;
      end
      S_DN_CMPR: cmd_o.cand_right = stat_i.right_wins;
      S_DN_CMP: begin
        cmd_o.descend   = stat_i.sink_more;
        cmd_o.wr_moving = !stat_i.sink_more;
      end
      S_UP_CHK: begin
        cmd_o.wr_moving = stat_i.at_root;
        cmd_o.heap_re   = !stat_i.at_root;
        cmd_o.heap_sel  = RD_PARENT;
      end
      S_UP_CMP: begin
        cmd_o.ascend    = stat_i.rise_more;
        cmd_o.wr_moving = !stat_i.rise_more;
      end
      S_DK_SLOT: begin
        cmd_o.dk_hole = 1'b1;
        if (stat_i.slot_bad) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_ABSENT;
        end else begin
          cmd_o.heap_re  = 1'b1;
          cmd_o.heap_sel = RD_SLOT;
        end
      end
      S_DK_KEY: begin
        if (stat_i.not_lower) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOT_LOWER;
        end else begin
          cmd_o.dk_moving = 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.heap_re  = 1'b1;
        cmd_o.heap_sel = RD_ROOT;
      end
      S_ROOT: cmd_o.out_load = !stat_i.out_busy;
      default: ;
    endcase
  end
endmodule

/* hdl/indexed_min_heap_queue.sv */
// top level of the indexed min-heap priority queue
// usage:
//   input channel: in_valid_i / in_stall_o with cmd_i, item_id_i, new_key_i
//   (insert, extract minimum, decrease key); a transfer happens when valid is
//   high and stall is low
//   output channel: out_valid_o / out_stall_i with status_o, out_id_o,
//   out_key_o and entry_count_o, exactly one result per input transfer
// sequencing:
//   one operation at a time; a rejected command goes straight to S_FIN,
//   from S_DECODE or, for a decrease, also from S_DK_SLOT or S_DK_KEY; a
//   sift-up visits S_UP_CHK and S_UP_CMP for each heap level and a
//   sift-down S_DN_RDL, S_DN_RDR, S_DN_CMPR (when a right child exists)
//   and S_DN_CMP, as set by the single read port of the heap memory
//   in_stall_o is low only while the sequencer is idle
// reset:
//   all items marked absent and the queue empty; the heap memory needs no
//   clearing pass, only slots below the entry count are ever used
// back-pressure:
//   a held result waits in the output register; the next request is still
//   taken and runs, and only its final result load waits for the transfer
module indexed_min_heap_queue import imhq_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              cmd_i,
  input  logic [ID_W-1:0]         item_id_i,
  input  logic signed [KEY_W-1:0] new_key_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              status_o,
  output logic [ID_W-1:0]         out_id_o,
  output logic signed [KEY_W-1:0] out_key_o,
  output logic [COUNT_W-1:0]      entry_count_o
);
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer: walks the heap one level at a time
  imhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // heap slots, position map, present bits and result register
  imhq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .cmd_in_i      (cmd_i),
    .item_id_i     (item_id_i),
    .new_key_i     (new_key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_id_o      (out_id_o),
    .out_key_o     (out_key_o),
    .entry_count_o (entry_count_o)
  );
endmodule
